FILE: hdl/dmtlb_pkg.sv
// Package of the direct-mapped soft TLB: entry layout, command codes, controller states
// and the hash constant. No dependencies; every other file of the block imports it.
package dmtlb_pkg;

   localparam int          INDEX_BITS_DEF = 9;
   localparam logic [31:0] HASH_MULT      = 32'd1315423911;

   typedef enum logic [2:0] {
      CMD_LOOKUP   = 3'd0,
      CMD_FILL     = 3'd1,
      CMD_INVAL    = 3'd2,
      CMD_SET_PERM = 3'd3,
      CMD_PURGE    = 3'd4,
      CMD_READ_CNT = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_WALK
   } state_type;

   // One slot: tag (process id, virtual page) and data (physical page, permissions).
   typedef struct packed {
      logic [15:0] pid;
      logic [31:0] vpage;
      logic [31:0] ppage;
      logic [11:0] perms;
   } entry_type;

endpackage

FILE: hdl/direct_mapped_soft_tlb.sv
// Top level of the direct-mapped soft TLB, built on dmtlb_mem and dmtlb_hash.
// Depends on dmtlb_pkg for command codes, states and the entry layout.
//
// A direct-mapped translation buffer of 2**INDEX_BITS slots (512 by default) held in one
// synchronous memory. After reset the block sweeps the memory writing zeros, one slot a
// cycle, and accepts no word until the sweep is done. Lookup, fill, invalidate, update
// permissions and read counters then run through a pipeline: a word accepted in one cycle
// has its slot read into the memory's read register, is resolved and written back in the
// resolve stage, and its result is then loaded into the output register, while the next
// word is already accepted. When a word reads the slot that the word ahead of it is writing
// in the same cycle, the written entry is forwarded in place of the stale read. A purge
// walks every slot through the single read port and clears behind it each slot that the
// purged process owns, and its result is offered only once the walk has ended. Results
// leave through one output register; while it is full and not taken, the word in the
// resolve stage waits and no new word is accepted. A cleared slot holds zeros and therefore
// matches process 0 with page 0. The hit and miss counters wrap.
module direct_mapped_soft_tlb #(
   parameter int INDEX_BITS = dmtlb_pkg::INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic signed [15:0] req_process_id,
   input  logic [31:0]        req_virt_page,
   input  logic [31:0]        req_phys_page,
   input  logic [11:0]        req_new_perms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [31:0]        rsp_phys_page_out,
   output logic [11:0]        rsp_perm_bits_out,
   output logic [31:0]        rsp_hit_total,
   output logic [31:0]        rsp_miss_total
);
   import dmtlb_pkg::*;

   // Controller state and the sweep pointer shared by the reset clear and the purge walk.
   state_type             state_ff, state_in;
   logic [INDEX_BITS:0]   ptr_ff, ptr_in;
   logic                  pend_ff, pend_in;
   logic [INDEX_BITS-1:0] pend_addr_ff, pend_addr_in;

   // Resolve stage: the word whose slot has just been read.
   logic                  s2_valid_ff, s2_valid_in;
   cmd_type               s2_cmd_ff, s2_cmd_in;
   logic [15:0]           s2_pid_ff, s2_pid_in;
   logic [31:0]           s2_vpage_ff, s2_vpage_in;
   logic [31:0]           s2_ppage_ff, s2_ppage_in;
   logic [11:0]           s2_perms_ff, s2_perms_in;
   logic [INDEX_BITS-1:0] s2_idx_ff, s2_idx_in;

   // Forwarded entry for a read that met a write to the same slot.
   logic                  fwd_ff, fwd_in;
   entry_type             fwd_entry_ff, fwd_entry_in;

   logic [31:0]           hit_cnt_ff, hit_cnt_in;
   logic [31:0]           miss_cnt_ff, miss_cnt_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [31:0]           rsp_ppage_ff, rsp_ppage_in;
   logic [11:0]           rsp_perms_ff, rsp_perms_in;
   logic [31:0]           rsp_hit_ff, rsp_hit_in;
   logic [31:0]           rsp_miss_ff, rsp_miss_in;

   // Memory ports and stage control.
   logic                  mem_wr_en;
   logic [INDEX_BITS-1:0] mem_wr_addr;
   entry_type             mem_wr_data;
   logic                  mem_rd_en;
   logic [INDEX_BITS-1:0] mem_rd_addr;
   entry_type             mem_rd_data;
   logic [INDEX_BITS-1:0] req_idx;
   entry_type             cur_entry;
   logic                  tag_match;
   logic                  out_free;
   logic                  s2_adv;
   logic                  accept;
   logic                  rsp_load;

   dmtlb_hash #(
      .INDEX_BITS (INDEX_BITS)
   ) u_hash (
      .pid   (req_process_id),
      .vpage (req_virt_page),
      .idx   (req_idx)
   );

   dmtlb_mem #(
      .INDEX_BITS (INDEX_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign cur_entry = fwd_ff ? fwd_entry_ff : mem_rd_data;
   assign tag_match = (cur_entry.pid == s2_pid_ff) && (cur_entry.vpage == s2_vpage_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = (state_ff == ST_RUN) && s2_valid_ff && (s2_cmd_ff != CMD_PURGE)
                      && out_free;
   assign req_ready = (state_ff == ST_RUN) && (!s2_valid_ff || s2_adv);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      s2_valid_in  = s2_valid_ff;
      s2_cmd_in    = s2_cmd_ff;
      s2_pid_in    = s2_pid_ff;
      s2_vpage_in  = s2_vpage_ff;
      s2_ppage_in  = s2_ppage_ff;
      s2_perms_in  = s2_perms_ff;
      s2_idx_in    = s2_idx_ff;
      fwd_in       = fwd_ff;
      fwd_entry_in = fwd_entry_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      rsp_load     = 1'b0;
      rsp_found_in = 1'b0;
      rsp_ppage_in = '0;
      rsp_perms_in = '0;
      rsp_hit_in   = '0;
      rsp_miss_in  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = s2_idx_ff;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = req_idx;

      case (state_ff)
         ST_CLEAR: begin
            // Zero one slot a cycle until the last one is written.
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff[INDEX_BITS-1:0];
            ptr_in      = ptr_ff + 1'b1;
            if (&ptr_ff[INDEX_BITS-1:0]) begin
               state_in = ST_RUN;
            end
         end

         ST_RUN: begin
            if (s2_adv) begin
               rsp_load = 1'b1;
               case (s2_cmd_ff)
                  CMD_LOOKUP: begin
                     if (tag_match) begin
                        rsp_found_in = 1'b1;
                        rsp_ppage_in = cur_entry.ppage;
                        rsp_perms_in = cur_entry.perms;
                        hit_cnt_in   = hit_cnt_ff + 32'd1;
                     end else begin
                        miss_cnt_in = miss_cnt_ff + 32'd1;
                     end
                  end
                  CMD_FILL: begin
                     mem_wr_en         = 1'b1;
                     mem_wr_data.pid   = s2_pid_ff;
                     mem_wr_data.vpage = s2_vpage_ff;
                     mem_wr_data.ppage = s2_ppage_ff;
                     mem_wr_data.perms = s2_perms_ff;
                  end
                  CMD_INVAL: begin
                     mem_wr_en = tag_match;
                  end
                  CMD_SET_PERM: begin
                     mem_wr_en         = tag_match;
                     mem_wr_data       = cur_entry;
                     mem_wr_data.perms = s2_perms_ff;
                  end
                  CMD_READ_CNT: begin
                     rsp_hit_in  = hit_cnt_ff;
                     rsp_miss_in = miss_cnt_ff;
                  end
                  default: begin
                  end
               endcase
            end

            if (s2_valid_ff && (s2_cmd_ff == CMD_PURGE)) begin
               // Start the walk; the purge result is offered when it ends.
               state_in    = ST_WALK;
               s2_valid_in = 1'b0;
               ptr_in      = '0;
               pend_in     = 1'b0;
            end else if (accept) begin
               s2_valid_in  = 1'b1;
               s2_cmd_in    = cmd_type'(req_command);
               s2_pid_in    = req_process_id;
               s2_vpage_in  = req_virt_page;
               s2_ppage_in  = req_phys_page;
               s2_perms_in  = req_new_perms;
               s2_idx_in    = req_idx;
               mem_rd_en    = 1'b1;
               // The memory returns the old entry when the slot is written this cycle.
               fwd_in       = mem_wr_en && (mem_wr_addr == req_idx);
               fwd_entry_in = mem_wr_data;
            end else if (s2_adv) begin
               s2_valid_in = 1'b0;
            end
         end

         ST_WALK: begin
            // Read one slot a cycle; clear the slot read last cycle if the process owns it.
            if (pend_ff && (mem_rd_data.pid == s2_pid_ff)) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_addr_ff;
            end
            if (!ptr_ff[INDEX_BITS]) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = ptr_ff[INDEX_BITS-1:0];
               ptr_in       = ptr_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[INDEX_BITS-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff && out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end

         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         s2_valid_ff  <= s2_valid_in;
         fwd_ff       <= fwd_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      s2_cmd_ff    <= s2_cmd_in;
      s2_pid_ff    <= s2_pid_in;
      s2_vpage_ff  <= s2_vpage_in;
      s2_ppage_ff  <= s2_ppage_in;
      s2_perms_ff  <= s2_perms_in;
      s2_idx_ff    <= s2_idx_in;
      fwd_entry_ff <= fwd_entry_in;
      if (rsp_load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_ppage_ff <= rsp_ppage_in;
         rsp_perms_ff <= rsp_perms_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_miss_ff  <= rsp_miss_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_phys_page_out = rsp_ppage_ff;
   assign rsp_perm_bits_out = rsp_perms_ff;
   assign rsp_hit_total     = rsp_hit_ff;
   assign rsp_miss_total    = rsp_miss_ff;

   // A new result must never overwrite one that is still waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   // No word enters while the store is being cleared or walked.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_RUN))
      else $error("word accepted outside normal operation");

   // The hit counter moves only as a lookup completes.
   assert property (@(posedge clock) disable iff (reset)
      (hit_cnt_ff != $past(hit_cnt_ff)) |-> $past(s2_adv && (s2_cmd_ff == CMD_LOOKUP)))
      else $error("hit counter changed without a lookup");

   // A purge keeps the result register untouched until its walk has ended.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && !ptr_ff[INDEX_BITS]) |-> !rsp_load)
      else $error("purge result offered before the walk ended");

endmodule

FILE: hdl/dmtlb_mem.sv
// Slot store of the direct-mapped soft TLB: one write port, one read port, registered read.
// Depends on dmtlb_pkg for the entry layout.
module dmtlb_mem #(
   parameter int INDEX_BITS = dmtlb_pkg::INDEX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [INDEX_BITS-1:0] wr_addr,
   input  dmtlb_pkg::entry_type  wr_data,
   input  logic                  rd_en,
   input  logic [INDEX_BITS-1:0] rd_addr,
   output dmtlb_pkg::entry_type  rd_data
);
   import dmtlb_pkg::*;

   localparam int SLOTS = 1 << INDEX_BITS;

   entry_type store_ff [SLOTS];
   entry_type rd_data_ff;

   // A read of the slot being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dmtlb_hash.sv
// Slot index of the direct-mapped soft TLB: low bits of (process id * constant) xor page.
// Depends on dmtlb_pkg for the hash constant.
module dmtlb_hash #(
   parameter int INDEX_BITS = dmtlb_pkg::INDEX_BITS_DEF
) (
   input  logic signed [15:0]     pid,
   input  logic [31:0]            vpage,
   output logic [INDEX_BITS-1:0]  idx
);
   import dmtlb_pkg::*;

   localparam logic [INDEX_BITS-1:0] MULT_LO = HASH_MULT[INDEX_BITS-1:0];

   logic [31:0]           pid_wide;
   logic [INDEX_BITS-1:0] prod;

   // Only the low index bits of the product are kept, so a narrow multiplier suffices.
   assign pid_wide = 32'(pid);
   assign prod     = pid_wide[INDEX_BITS-1:0] * MULT_LO;
   assign idx      = prod ^ vpage[INDEX_BITS-1:0];

endmodule

FILE: tb/sv/direct_mapped_soft_tlb_tb.sv
// Self-checking testbench for direct_mapped_soft_tlb: a command driver, a reply checker with
// its own translation model, and a random sink. Depends on dmtlb_pkg and the RTL.
module direct_mapped_soft_tlb_tb;
   import dmtlb_pkg::*;

   // The block is built with its default geometry, so the model uses the same slot count.
   localparam int INDEX_BITS = INDEX_BITS_DEF;
   localparam int SLOTS = 1 << INDEX_BITS;
   localparam int RANDOM_WORDS = 750;

   // Codes 6 and 7 are not decoded by the block and must change nothing.
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   // The slowest stretch without any handshake is the clearing sweep after reset or a purge
   // walk, plus a sender gap and a long sink stall on top.
   // The limit allows for several times that.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [15:0] pid;
      logic [31:0] vpage;
   } tlb_tag_type;

   // One command word as queued for the driver. A word with hold_until_idle set is not sent:
   // it makes the driver wait until every outstanding reply has been returned.
   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] process_id;
      logic [31:0] virt_page;
      logic [31:0] phys_page;
      logic [11:0] new_perms;
      logic        hold_until_idle;
   } tlb_word_type;

   typedef struct packed {
      logic        found;
      logic [31:0] phys_page;
      logic [11:0] perms;
      logic [31:0] hits;
      logic [31:0] misses;
   } tlb_reply_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_JITTER,
      SINK_BLOCKS
   } sink_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_command = '0;
   logic signed [15:0] req_process_id = '0;
   logic [31:0]        req_virt_page = '0;
   logic [31:0]        req_phys_page = '0;
   logic [11:0]        req_new_perms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic [31:0]        rsp_phys_page_out;
   logic [11:0]        rsp_perm_bits_out;
   logic [31:0]        rsp_hit_total;
   logic [31:0]        rsp_miss_total;

   // Translation model: the slot store and the two wrapping counters.
   entry_type   slot_model [SLOTS];
   logic [31:0] hit_tally;
   logic [31:0] miss_tally;

   tlb_word_type  command_queue [$];
   tlb_reply_type predicted_replies [$];

   logic req_taken;
   int   idle_cycles;
   int   error_count = 0;
   int   words_accepted = 0;
   int   replies_checked = 0;
   int   fill_count = 0;
   int   purge_count = 0;

   direct_mapped_soft_tlb i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_process_id    (req_process_id),
      .req_virt_page     (req_virt_page),
      .req_phys_page     (req_phys_page),
      .req_new_perms     (req_new_perms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_phys_page_out (rsp_phys_page_out),
      .rsp_perm_bits_out (rsp_perm_bits_out),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_miss_total    (rsp_miss_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The slot is the low index bits of the sign-extended process id times the hash
   // multiplier, modulo 2**32, exclusive-ored with the virtual page.
   function automatic logic [INDEX_BITS-1:0] slot_of_tag(tlb_tag_type t);
      logic [31:0] pid_wide;
      logic [31:0] mixed;
      pid_wide = {{16{t.pid[15]}}, t.pid};
      mixed = pid_wide * HASH_MULT;
      return mixed[INDEX_BITS-1:0] ^ t.vpage[INDEX_BITS-1:0];
   endfunction

   // Process ids stay within -1 to 32767; small ids and the kernel are favoured so that
   // purges and collisions between processes find something to act on.
   function automatic logic [15:0] random_pid();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return 16'hFFFF;
      if (r < 3)
         return 16'($urandom_range(0, 7));
      return 16'($urandom_range(0, 32767));
   endfunction

   // A different tag that lands in the same slot, either from the same process with other
   // upper page bits or from another process with the low page bits adjusted.
   function automatic tlb_tag_type alias_of(tlb_tag_type t);
      tlb_tag_type a;
      tlb_tag_type probe;
      if ($urandom_range(0, 1) == 0) begin
         a.pid = t.pid;
         a.vpage = t.vpage ^ (($urandom | (32'd1 << INDEX_BITS)) & ~32'(SLOTS - 1));
      end else begin
         a.pid = random_pid();
         probe.pid = a.pid;
         probe.vpage = '0;
         a.vpage = $urandom;
         a.vpage[INDEX_BITS-1:0] = slot_of_tag(t) ^ slot_of_tag(probe);
      end
      return a;
   endfunction

   task automatic queue_word(logic [2:0] cmd, tlb_tag_type t, logic [31:0] pp, logic [11:0] pm);
      tlb_word_type w;
      w.command = cmd;
      w.process_id = t.pid;
      w.virt_page = t.vpage;
      w.phys_page = pp;
      w.new_perms = pm;
      w.hold_until_idle = 1'b0;
      command_queue.push_back(w);
   endtask

   task automatic queue_pause();
      tlb_word_type w;
      w = '0;
      w.hold_until_idle = 1'b1;
      command_queue.push_back(w);
   endtask

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= 10)
         $display("ERROR: %s", msg);
   endtask

   // Works out the reply to one accepted word and applies its effect on the model state.
   // Every field that the command does not name stays zero.
   function automatic tlb_reply_type translate_word(tlb_word_type w);
      tlb_reply_type r;
      tlb_tag_type t;
      logic [INDEX_BITS-1:0] idx;
      logic match;
      int i;
      r = '0;
      t.pid = w.process_id;
      t.vpage = w.virt_page;
      idx = slot_of_tag(t);
      match = (slot_model[idx].pid == t.pid) && (slot_model[idx].vpage == t.vpage);
      case (w.command)
         CMD_LOOKUP: begin
            if (match) begin
               r.found = 1'b1;
               r.phys_page = slot_model[idx].ppage;
               r.perms = slot_model[idx].perms;
               hit_tally = hit_tally + 32'd1;
            end else begin
               miss_tally = miss_tally + 32'd1;
            end
         end
         CMD_FILL: begin
            slot_model[idx].pid = t.pid;
            slot_model[idx].vpage = t.vpage;
            slot_model[idx].ppage = w.phys_page;
            slot_model[idx].perms = w.new_perms;
            fill_count++;
         end
         CMD_INVAL: begin
            if (match)
               slot_model[idx] = '0;
         end
         CMD_SET_PERM: begin
            if (match)
               slot_model[idx].perms = w.new_perms;
         end
         CMD_PURGE: begin
            for (i = 0; i < SLOTS; i++)
               if (slot_model[i].pid == t.pid)
                  slot_model[i] = '0;
            purge_count++;
         end
         CMD_READ_CNT: begin
            r.hits = hit_tally;
            r.misses = miss_tally;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Driver. Inputs change on the falling edge only. The word on the port is held until the
   // rising edge that accepts it, which req_taken records. The sender alternates bursts of
   // random length with gaps of random length, and about a quarter of the bursts are
   // followed by no gap at all, so that long back-to-back stretches occur as well.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin : word_driver
      tlb_word_type w;
      logic next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         next_valid = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (command_queue.size() != 0) begin
            if (command_queue[0].hold_until_idle) begin
               // The sender stays quiet until the block has answered everything.
               if (predicted_replies.size() == 0)
                  command_queue.delete(0);
            end else begin
               w = command_queue.pop_front();
               req_command <= w.command;
               req_process_id <= w.process_id;
               req_virt_page <= w.virt_page;
               req_phys_page <= w.phys_page;
               req_new_perms <= w.new_perms;
               next_valid = 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 31);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // Sink. The receiver switches between always ready, random jitter and blocks of stalled
   // cycles, holding each behaviour for a random stretch.
   sink_mode_type sink_mode = SINK_OPEN;
   int sink_phase_left = 0;
   int sink_hold_left = 0;

   always @(negedge clock) begin : sink_pattern
      logic take;
      if (sink_phase_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 2));
         sink_phase_left = $urandom_range(20, 120);
      end
      sink_phase_left--;
      case (sink_mode)
         SINK_OPEN: take = 1'b1;
         SINK_JITTER: take = ($urandom_range(0, 3) != 0);
         default: begin
            if (sink_hold_left != 0) begin
               sink_hold_left--;
               take = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               sink_hold_left = $urandom_range(1, 9);
               take = 1'b0;
            end else begin
               take = 1'b1;
            end
         end
      endcase
      rsp_ready <= take;
   end

   // Checker. Everything is sampled on the rising edge. A reply is compared with the oldest
   // prediction before the word accepted on the same edge is modelled; this is safe because
   // a reply always belongs to a word accepted at an earlier edge.
   always @(posedge clock) begin : reply_checker
      tlb_reply_type got;
      tlb_reply_type want;
      tlb_word_type w;
      string bad;
      int i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++)
            slot_model[i] = '0;
         hit_tally = '0;
         miss_tally = '0;
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            got.found = rsp_found;
            got.phys_page = rsp_phys_page_out;
            got.perms = rsp_perm_bits_out;
            got.hits = rsp_hit_total;
            got.misses = rsp_miss_total;
            if (predicted_replies.size() == 0) begin
               note_error($sformatf(
                  "unexpected reply found=%0d phys=%h perms=%h hits=%0d misses=%0d",
                  got.found, got.phys_page, got.perms, got.hits, got.misses));
            end else begin
               want = predicted_replies.pop_front();
               bad = "";
               if (got.found !== want.found)
                  bad = {bad, " found"};
               if (got.phys_page !== want.phys_page)
                  bad = {bad, " phys_page_out"};
               if (got.perms !== want.perms)
                  bad = {bad, " perm_bits_out"};
               if (got.hits !== want.hits)
                  bad = {bad, " hit_total"};
               if (got.misses !== want.misses)
                  bad = {bad, " miss_total"};
               if (bad != "")
                  note_error($sformatf(
                     "reply %0d wrong in%s: expected %0d/%h/%h/%0d/%0d, got %0d/%h/%h/%0d/%0d",
                     replies_checked, bad, want.found, want.phys_page, want.perms, want.hits,
                     want.misses, got.found, got.phys_page, got.perms, got.hits, got.misses));
               replies_checked++;
            end
         end
         if (req_valid && req_ready) begin
            w.command = req_command;
            w.process_id = req_process_id;
            w.virt_page = req_virt_page;
            w.phys_page = req_phys_page;
            w.new_perms = req_new_perms;
            w.hold_until_idle = 1'b0;
            predicted_replies.push_back(translate_word(w));
            words_accepted++;
         end
      end
   end

   initial begin : main_sequence
      tlb_tag_type zero_tag;
      tlb_tag_type kernel_tag;
      tlb_tag_type top_tag;
      tlb_tag_type tag_a;
      tlb_tag_type tag_a_twin;
      tlb_tag_type tag_p1;
      tlb_tag_type tag_p2;
      tlb_tag_type known;
      tlb_tag_type fresh;
      tlb_tag_type t;
      tlb_tag_type live_tags [$];
      int n;
      int r;
      int s;

      zero_tag = '0;
      kernel_tag = {16'hFFFF, 32'hFFFF_FFFF};
      top_tag = {16'h7FFF, 32'h0000_0000};
      tag_a = {16'h1234, 32'h89AB_C000};
      // Same process, other upper page bits, same slot as tag_a.
      tag_a_twin = {16'h1234, 32'h89AA_C000};
      tag_p1 = {16'h0005, 32'h0000_1000};
      tag_p2 = {16'h0005, 32'h0000_2000};

      // Directed part. A freshly cleared slot already hits for process 0, page 0.
      queue_word(CMD_LOOKUP, zero_tag, 32'hFFFF_FFFF, 12'hFFF);
      queue_word(CMD_LOOKUP, kernel_tag, $urandom, 12'($urandom));
      queue_word(CMD_READ_CNT, kernel_tag, 32'hFFFF_FFFF, 12'hFFF);
      // A kernel entry with every data bit set, looked up back to back with its fill.
      queue_word(CMD_FILL, kernel_tag, 32'hFFFF_FFFF, 12'hFFF);
      queue_word(CMD_LOOKUP, kernel_tag, 32'h0, 12'h0);
      queue_word(CMD_FILL, top_tag, 32'h0, 12'h0);
      queue_word(CMD_LOOKUP, top_tag, $urandom, 12'($urandom));
      // Permission update on a match, then an update and an invalidate on a tag that only
      // shares the slot, neither of which may touch the entry.
      queue_word(CMD_FILL, tag_a, 32'h5555_AAAA, 12'hA5A);
      queue_word(CMD_SET_PERM, tag_a, $urandom, 12'h5A5);
      queue_word(CMD_LOOKUP, tag_a, $urandom, 12'($urandom));
      queue_word(CMD_SET_PERM, tag_a_twin, $urandom, 12'h0F0);
      queue_word(CMD_INVAL, tag_a_twin, $urandom, 12'($urandom));
      queue_word(CMD_LOOKUP, tag_a, $urandom, 12'($urandom));
      queue_word(CMD_INVAL, tag_a, $urandom, 12'($urandom));
      queue_word(CMD_LOOKUP, tag_a, $urandom, 12'($urandom));
      // Purges of an ordinary process and of the kernel.
      queue_word(CMD_FILL, tag_p1, $urandom, 12'($urandom));
      queue_word(CMD_FILL, tag_p2, $urandom, 12'($urandom));
      queue_word(CMD_PURGE, tag_p1, $urandom, 12'($urandom));
      queue_word(CMD_LOOKUP, tag_p1, $urandom, 12'($urandom));
      queue_word(CMD_LOOKUP, tag_p2, $urandom, 12'($urandom));
      queue_word(CMD_PURGE, kernel_tag, $urandom, 12'($urandom));
      queue_word(CMD_LOOKUP, kernel_tag, $urandom, 12'($urandom));
      // The two unused command codes, with every other field at all ones.
      queue_word(CMD_SPARE6, kernel_tag, 32'hFFFF_FFFF, 12'hFFF);
      queue_word(CMD_SPARE7, kernel_tag, 32'hFFFF_FFFF, 12'hFFF);
      queue_word(CMD_READ_CNT, zero_tag, 32'h0, 12'h0);
      queue_pause();

      // Random part. Most lookups, invalidates and permission updates act on tags that were
      // filled recently, so that they mostly hit; other words use fresh tags, tags that collide
      // in a slot or the cleared tag, or are counter reads, unused codes and the odd purge.
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 2)
            queue_pause();
         r = $urandom_range(0, 99);
         fresh.pid = random_pid();
         fresh.vpage = $urandom;
         if (live_tags.size() != 0)
            known = live_tags[$urandom_range(0, live_tags.size() - 1)];
         else
            known = fresh;
         if (r < 22) begin
            t = ($urandom_range(0, 9) < 3) ? alias_of(known) : fresh;
            queue_word(CMD_FILL, t, $urandom, 12'($urandom));
            live_tags.push_back(t);
            if (live_tags.size() > 24)
               live_tags.delete(0);
         end else if (r < 62) begin
            s = $urandom_range(0, 19);
            t = (s < 15) ? known : ((s < 17) ? zero_tag : fresh);
            queue_word(CMD_LOOKUP, t, $urandom, 12'($urandom));
         end else if (r < 70) begin
            t = ($urandom_range(0, 4) != 0) ? known : alias_of(known);
            queue_word(CMD_INVAL, t, $urandom, 12'($urandom));
         end else if (r < 80) begin
            t = ($urandom_range(0, 4) != 0) ? known : alias_of(known);
            queue_word(CMD_SET_PERM, t, $urandom, 12'($urandom));
         end else if (r < 89) begin
            queue_word(CMD_READ_CNT, fresh, $urandom, 12'($urandom));
         end else if (r < 91) begin
            queue_word((r == 89) ? CMD_SPARE6 : CMD_SPARE7, fresh, $urandom, 12'($urandom));
         end else if (r < 92) begin
            queue_word(CMD_PURGE, known, $urandom, 12'($urandom));
         end else begin
            queue_word(CMD_LOOKUP, alias_of(known), $urandom, 12'($urandom));
         end
      end
      queue_word(CMD_READ_CNT, zero_tag, $urandom, 12'($urandom));

      // Reset is released with a nonblocking write so that the driver, which also wakes on this
      // falling edge, still sees it asserted.
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      while ((command_queue.size() != 0 || req_valid || predicted_replies.size() != 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         error_count++;
         $display("ERROR: no handshake for %0d cycles, %0d replies outstanding",
            WATCHDOG_LIMIT, predicted_replies.size());
      end else begin
         // Let the pipeline run on so that a stray extra reply would still be caught.
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (predicted_replies.size() != 0)
            note_error($sformatf("%0d replies never arrived", predicted_replies.size()));
      end

      $display("Summary: %0d words accepted, %0d replies checked, %0d fills, %0d purges.",
         words_accepted, replies_checked, fill_count, purge_count);
      $display("Summary: lookups gave %0d hits and %0d misses; %0d errors in all.",
         hit_tally, miss_tally, error_count);
      if (error_count == 0)
         $display("direct_mapped_soft_tlb_tb OK");
      else
         $display("direct_mapped_soft_tlb_tb NOT OK");
      $finish;
   end

endmodule

FILE: direct_mapped_soft_tlb.f
hdl/dmtlb_pkg.sv
hdl/dmtlb_mem.sv
hdl/dmtlb_hash.sv
hdl/direct_mapped_soft_tlb.sv
tb/sv/direct_mapped_soft_tlb_tb.sv
